// ----- src/lrdm_pkg.sv -----
// Shared types and constants for the loop rate deadline monitor.
// Holds the controller state, the command and status structs and fixed widths.
// No dependencies.
package lrdm_pkg;

  // Default build parameters
  localparam int COUNT_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Fixed field widths
  localparam int TS_W        = 64;
  localparam int RATE_W      = 48;
  localparam int CNT_OUT_W   = 32;
  localparam int CHUNK_W     = 16;
  localparam int NS_W        = 30;
  localparam int CFG_IDX_W   = 1;

  // Result transaction layout
  localparam int OUT_USED_W  = 1 + CNT_OUT_W + CNT_OUT_W + 3 * RATE_W + 1;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  // Nanoseconds per second
  localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_COMMIT
  } lrdm_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;       // capture timestamp and tick count
    logic mul_step;  // one chunk of count * 1e9
    logic div_load;  // load both dividers
    logic div_step;  // one quotient bit in both dividers
    logic commit;    // update statistics and result register
  } lrdm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rate_path; // this tick computes rates
  } lrdm_sts_t;

endpackage

// ----- src/lrdm_div.sv -----
// Bit-serial restoring divider with 48-bit saturating quotient.
// One quotient bit per step; a zero divisor yields all ones. Uses lrdm_pkg.
module lrdm_div #(
  parameter int DW = 78
) (
  input  logic                           clk,
  input  logic                           load,
  input  logic                           step,
  input  logic [DW-1:0]                  dividend,
  input  logic [lrdm_pkg::TS_W-1:0]      divisor,
  output logic [lrdm_pkg::RATE_W-1:0]    quot
);

  logic [DW-1:0]                 dvd_r;
  logic [lrdm_pkg::TS_W-1:0]     rem_r;
  logic [lrdm_pkg::TS_W-1:0]     dsr_r;
  logic [lrdm_pkg::RATE_W-1:0]   q_r;
  logic                          sat_r;
  logic                          zero_r;

  logic [lrdm_pkg::TS_W:0]       trial;
  logic [lrdm_pkg::TS_W:0]       diff;
  logic                          ge;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_r, dvd_r[DW-1]};
    ge    = trial >= {1'b0, dsr_r};
    diff  = trial - {1'b0, dsr_r};
  end

  // Advance one quotient bit per step; bits leaving the top mark saturation
  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
      q_r    <= '0;
      sat_r  <= 1'b0;
      zero_r <= (divisor == '0);
    end else if (step) begin
      dvd_r  <= dvd_r << 1;
      rem_r  <= ge ? diff[lrdm_pkg::TS_W-1:0] : trial[lrdm_pkg::TS_W-1:0];
      q_r    <= {q_r[lrdm_pkg::RATE_W-2:0], ge};
      sat_r  <= sat_r | q_r[lrdm_pkg::RATE_W-1];
    end
  end

  assign quot = (zero_r || sat_r) ? {lrdm_pkg::RATE_W{1'b1}} : q_r;

endmodule

// ----- src/lrdm_dp.sv -----
// Datapath: statistics registers, count * 1e9 multiplier and two rate dividers.
// Driven by lrdm_ctrl commands; uses lrdm_pkg and lrdm_div.
module lrdm_dp #(
  parameter int COUNT_WIDTH = lrdm_pkg::COUNT_WIDTH,
  parameter int FRAC_BITS   = lrdm_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [lrdm_pkg::TS_W-1:0]           in_tdata,
  input  lrdm_pkg::lrdm_cmd_t                 cmd,
  output lrdm_pkg::lrdm_sts_t                 sts,
  input  logic                                cfg_wr_en,
  input  logic [lrdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrdm_pkg::RATE_W-1:0]         cfg_wdata,
  output logic [lrdm_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int CW    = COUNT_WIDTH;
  localparam int NCH   = (CW + lrdm_pkg::CHUNK_W - 1) / lrdm_pkg::CHUNK_W;
  localparam int CHW   = NCH * lrdm_pkg::CHUNK_W;
  localparam int PW    = CW + lrdm_pkg::NS_W;
  localparam int PPW   = lrdm_pkg::CHUNK_W + lrdm_pkg::NS_W;
  localparam int MW    = (PW > PPW) ? PW : PPW;
  localparam int DW    = PW + FRAC_BITS;
  localparam int RW    = lrdm_pkg::RATE_W;
  localparam int TW    = lrdm_pkg::TS_W;
  localparam logic [CW-1:0] LIMIT = {{(CW-1){1'b1}}, 1'b0};

  // Statistics state
  logic          active_r,  active_nxt;
  logic [CW-1:0] ticks_r,   ticks_nxt;
  logic [CW-1:0] misses_r,  misses_nxt;
  logic [TW-1:0] start_r,   start_nxt;
  logic [TW-1:0] prev_r,    prev_nxt;
  logic [RW-1:0] latest_r,  latest_nxt;
  logic [RW-1:0] lowest_r,  lowest_nxt;
  logic [RW-1:0] mean_r,    mean_nxt;
  logic [RW-1:0] min_rate_r;

  // Working registers
  logic [TW-1:0]  t_r;
  logic [CHW-1:0] count_r;
  logic [MW-1:0]  acc_r;
  logic [lrdm_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [CW-1:0]  ticks_inc;
  logic           held;
  logic           hit_limit;
  logic [MW-1:0]  partial;
  logic [DW-1:0]  inst_dvd;
  logic [DW-1:0]  mean_dvd;
  logic [RW-1:0]  inst_q;
  logic [RW-1:0]  mean_q;

  // Classify the pending tick from the held state
  always_comb begin
    ticks_inc     = ticks_r + 1'b1;
    held          = ticks_r >= LIMIT;
    hit_limit     = ticks_inc >= LIMIT;
    sts.rate_path = !held && !hit_limit && active_r;
  end

  // Capture the tick and build count * 1e9 one chunk at a time, top chunk first
  assign partial = MW'(count_r[CHW-1 -: lrdm_pkg::CHUNK_W]) * MW'(lrdm_pkg::NS_PER_SEC);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      t_r     <= in_tdata;
      count_r <= CHW'(ticks_inc);
      acc_r   <= '0;
    end else if (cmd.mul_step) begin
      count_r <= count_r << lrdm_pkg::CHUNK_W;
      acc_r   <= (acc_r << lrdm_pkg::CHUNK_W) + partial;
    end
  end

  // Dividends: 1e9 and count * 1e9, scaled by the fraction bits
  assign inst_dvd = DW'(lrdm_pkg::NS_PER_SEC) << FRAC_BITS;
  assign mean_dvd = DW'(acc_r[PW-1:0]) << FRAC_BITS;

  lrdm_div #(.DW(DW)) u_div_inst (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (inst_dvd),
    .divisor  (t_r - prev_r),
    .quot     (inst_q)
  );

  lrdm_div #(.DW(DW)) u_div_mean (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (mean_dvd),
    .divisor  (t_r - start_r),
    .quot     (mean_q)
  );

  // Next statistics for the tick being committed
  always_comb begin
    active_nxt = active_r;
    ticks_nxt  = ticks_r;
    misses_nxt = misses_r;
    start_nxt  = start_r;
    prev_nxt   = prev_r;
    latest_nxt = latest_r;
    lowest_nxt = lowest_r;
    mean_nxt   = mean_r;
    if (!held) begin
      ticks_nxt = ticks_inc;
      if (hit_limit) begin
        active_nxt = 1'b0;
      end else if (!active_r) begin
        start_nxt  = t_r;
        prev_nxt   = t_r;
        active_nxt = 1'b1;
      end else begin
        latest_nxt = inst_q;
        if (inst_q < min_rate_r) begin
          misses_nxt = misses_r + 1'b1;
        end
        if (inst_q < lowest_r) begin
          lowest_nxt = inst_q;
        end
        mean_nxt = mean_q;
        prev_nxt = t_r;
      end
    end
    out_data_nxt = {{lrdm_pkg::OUT_PAD_W{1'b0}},
                    active_nxt && (misses_nxt != '0),
                    mean_nxt, lowest_nxt, latest_nxt,
                    lrdm_pkg::CNT_OUT_W'(misses_nxt),
                    lrdm_pkg::CNT_OUT_W'(ticks_nxt),
                    active_nxt};
  end

  // Statistics registers update on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ticks_r  <= '0;
      misses_r <= '0;
      start_r  <= '0;
      prev_r   <= '0;
      latest_r <= '1;
      lowest_r <= '1;
      mean_r   <= '0;
    end else if (cmd.commit) begin
      active_r <= active_nxt;
      ticks_r  <= ticks_nxt;
      misses_r <= misses_nxt;
      start_r  <= start_nxt;
      prev_r   <= prev_nxt;
      latest_r <= latest_nxt;
      lowest_r <= lowest_nxt;
      mean_r   <= mean_nxt;
    end
  end

  // Load the result register on commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tdata = out_data_r;

  // Decode configuration writes; the nominal rate affects no statistic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rate_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lrdm_pkg::REG_MIN_RATE:    min_rate_r <= cfg_wdata;
        lrdm_pkg::REG_TARGET_RATE: min_rate_r <= min_rate_r;
      endcase
    end
  end

  // Tick count never goes backward across a commit
  a_ticks_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> ticks_r >= $past(ticks_r))
    else $error("tick count decreased");

  // Worst rate never exceeds the latest rate
  a_worst_le_latest: assert property (@(posedge clk) disable iff (!rst_n)
    lowest_r <= latest_r)
    else $error("worst rate above current rate");

  // Monitoring implies a live count below the limit
  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (ticks_r != '0 && ticks_r < LIMIT))
    else $error("monitoring with count out of range");

endmodule

// ----- src/lrdm_ctrl.sv -----
// Controller: sequences capture, multiply, divide and commit for each tick.
// Owns the handshakes and the result valid flag; uses lrdm_pkg.
module lrdm_ctrl #(
  parameter int COUNT_WIDTH = lrdm_pkg::COUNT_WIDTH,
  parameter int FRAC_BITS   = lrdm_pkg::FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  lrdm_pkg::lrdm_sts_t   sts,
  output lrdm_pkg::lrdm_cmd_t   cmd
);

  localparam int NCH   = (COUNT_WIDTH + lrdm_pkg::CHUNK_W - 1) / lrdm_pkg::CHUNK_W;
  localparam int DW    = COUNT_WIDTH + lrdm_pkg::NS_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DW);

  lrdm_pkg::lrdm_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // State, step counter and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrdm_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      lrdm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap = 1'b1;
          cnt_nxt = '0;
          state_nxt = sts.rate_path ? lrdm_pkg::ST_MUL : lrdm_pkg::ST_COMMIT;
        end
      end
      lrdm_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == CNT_W'(NCH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = lrdm_pkg::ST_LOAD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      lrdm_pkg::ST_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = lrdm_pkg::ST_DIV;
      end
      lrdm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = lrdm_pkg::ST_COMMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      lrdm_pkg::ST_COMMIT: begin
        // Hold until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = lrdm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrdm_pkg::ST_IDLE;
      end
    endcase
  end

  // Result valid: set on commit, drop once the transaction is taken
  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  // A tick without rates goes straight to commit
  a_fast_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !sts.rate_path) |=> state_r == lrdm_pkg::ST_COMMIT)
    else $error("tick without rates did not go to commit");

  // Division starts from step zero after the load
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_load |=> (state_r == lrdm_pkg::ST_DIV && cnt_r == '0))
    else $error("division did not start after load");

  // A commit always presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result valid");

endmodule

// ----- src/loop_rate_deadline_monitor.sv -----
// Loop rate deadline monitor top level: tick timestamps in, rate statistics out.
// The first tick and ticks at or past the count limit go from accept straight to commit;
// ticks that compute rates pass through the multiply, divider load and divide states
// before commit; the bit-serial dividers produce one quotient bit per cycle.
// The next tick is accepted in the cycle after commit, not before; commit waits
// while an untaken result is held. The two dividers run in parallel.
// Reset: synchronous active-low rst_n resets all statistics (current and worst rate to all ones) and min_rate at once.
module loop_rate_deadline_monitor #(
  parameter int COUNT_WIDTH = lrdm_pkg::COUNT_WIDTH,
  parameter int FRAC_BITS   = lrdm_pkg::FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [63:0] timestamp_ns
  input  logic [lrdm_pkg::TS_W-1:0]         in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] monitoring, [32:1] tick_count, [64:33] miss_count, [112:65] current_rate,
  // [160:113] worst_rate, [208:161] average_rate, [209] realtime_lost, rest zero
  output logic [lrdm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [lrdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lrdm_pkg::RATE_W-1:0]       cfg_wdata
);

  lrdm_pkg::lrdm_cmd_t cmd;
  lrdm_pkg::lrdm_sts_t sts;

  lrdm_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lrdm_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

endmodule
